// ===== sv/fpsa_pkg.sv =====
// shared types, constants and helpers for the free page stack allocator
package fpsa_pkg;

   localparam int STACK_DEPTH = 32768;
   localparam int PAGE_BYTES  = 4096;

   localparam int ADDR_W      = 34;
   localparam int BYTES_W     = 28;
   localparam int CMD_W       = 2;
   localparam int STATUS_W    = 2;
   localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
   localparam int PAGE_NUM_W  = ADDR_W - PAGE_SHIFT;
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W       = $clog2(STACK_DEPTH);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 64;

   localparam logic [ADDR_W-1:0]  LOWER_LIMIT_RESET = 34'h0_8000_0000;
   localparam logic [ADDR_W-1:0]  UPPER_LIMIT_RESET = 34'h0_8800_0000;
   localparam logic [BYTES_W-1:0] BYTES_MAX         = '1;

   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd3;

   // register index carried by paddr bit 3 (registers are 8 bytes apart)
   localparam logic REG_LOWER_LIMIT = 1'b0;
   localparam logic REG_UPPER_LIMIT = 1'b1;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   page_address;
      logic [BYTES_W-1:0]  free_bytes;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] lower_limit;
      logic [ADDR_W-1:0] upper_limit;
   } limits_type;

   typedef enum logic [1:0] {
      OP_POP,
      OP_PUSH,
      OP_BAD,
      OP_QUERY
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [PAGE_NUM_W-1:0] page;
   } entry_type;

   // free pages times page size, saturating at the field maximum
   function automatic logic [BYTES_W-1:0] bytes_of(input logic [COUNT_W-1:0] count);
      logic [63:0] prod;
      prod = 64'(count) << PAGE_SHIFT;
      if (prod > 64'(BYTES_MAX)) begin
         return BYTES_MAX;
      end
      return prod[BYTES_W-1:0];
   endfunction

endpackage

// ===== sv/fpsa_csr.sv =====
// limit registers behind the apb-style configuration port
module fpsa_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [fpsa_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [fpsa_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [fpsa_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output fpsa_pkg::limits_type              limits
);
   import fpsa_pkg::*;

   logic [ADDR_W-1:0] lower_ff, lower_in;
   logic [ADDR_W-1:0] upper_ff, upper_in;
   logic              wr_en;
   logic              reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[3];

   always_comb begin
      lower_in = lower_ff;
      upper_in = upper_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_LOWER_LIMIT: lower_in = csr_pwdata[ADDR_W-1:0];
            REG_UPPER_LIMIT: upper_in = csr_pwdata[ADDR_W-1:0];
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff <= LOWER_LIMIT_RESET;
         upper_ff <= UPPER_LIMIT_RESET;
      end else begin
         lower_ff <= lower_in;
         upper_ff <= upper_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_LOWER_LIMIT: csr_prdata = CSR_DATA_W'(lower_ff);
         REG_UPPER_LIMIT: csr_prdata = CSR_DATA_W'(upper_ff);
         default:         csr_prdata = '0;
      endcase
   end

   assign limits.lower_limit = lower_ff;
   assign limits.upper_limit = upper_ff;

endmodule

// ===== sv/fpsa_front.sv =====
// front end: takes commands and sorts them into stack operations
module fpsa_front (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  fpsa_pkg::req_type    req_data,
   input  fpsa_pkg::limits_type limits,
   output logic                 q_valid,
   input  logic                 q_ready,
   output fpsa_pkg::entry_type  q_data
);
   import fpsa_pkg::*;

   logic aligned;
   logic in_range;

   assign req_ready = q_ready;
   assign q_valid   = req_valid;

   assign aligned  = (req_data.address[PAGE_SHIFT-1:0] == '0);
   assign in_range = (req_data.address >= limits.lower_limit)
                  && (req_data.address <  limits.upper_limit);

   always_comb begin
      q_data.page = req_data.address[ADDR_W-1:PAGE_SHIFT];
      unique case (req_data.command)
         CMD_ALLOC: q_data.op = OP_POP;
         CMD_FREE:  q_data.op = (aligned && in_range) ? OP_PUSH : OP_BAD;
         // the unused code behaves as a query
         default:   q_data.op = OP_QUERY;
      endcase
   end

endmodule

// ===== sv/fpsa_queue.sv =====
// short fifo between the front and back ends
module fpsa_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  fpsa_pkg::entry_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output fpsa_pkg::entry_type out_data
);
   import fpsa_pkg::*;

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] fill_ff, fill_in;
   logic              push;
   logic              pop;

   assign in_ready  = (fill_ff != QCNT_W'(QUEUE_DEPTH));
   assign out_valid = (fill_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ===== sv/fpsa_back.sv =====
// back end: page stack memory, running count and result register
module fpsa_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_ready,
   input  fpsa_pkg::entry_type q_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output fpsa_pkg::rsp_type   rsp_data
);
   import fpsa_pkg::*;

   typedef enum logic {
      ST_RUN,
      ST_POP_WAIT
   } state_type;

   state_type             state_ff, state_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic [PAGE_NUM_W-1:0] stack_mem [STACK_DEPTH];
   logic [PAGE_NUM_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]      mem_idx;
   logic                  mem_we;
   logic                  mem_re;
   logic                  take;
   logic                  load;

   assign q_ready   = (state_ff == ST_RUN) && (!rsp_valid_ff || rsp_ready);
   assign take      = q_valid && q_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in                 = state_ff;
      count_in                 = count_ff;
      mem_we                   = 1'b0;
      mem_re                   = 1'b0;
      mem_idx                  = count_ff[IDX_W-1:0];
      load                     = 1'b0;
      rsp_data_in.page_address = '0;
      rsp_data_in.status       = STATUS_OK;
      unique case (state_ff)
         ST_POP_WAIT: begin
            // read data of the popped entry is now registered
            load                     = 1'b1;
            rsp_data_in.page_address = {rd_data_ff, {PAGE_SHIFT{1'b0}}};
            state_in                 = ST_RUN;
         end
         ST_RUN: begin
            if (take) begin
               unique case (q_data.op)
                  OP_POP: begin
                     if (count_ff == '0) begin
                        load               = 1'b1;
                        rsp_data_in.status = STATUS_EMPTY;
                     end else begin
                        count_in = count_ff - 1'b1;
                        mem_idx  = count_in[IDX_W-1:0];
                        mem_re   = 1'b1;
                        state_in = ST_POP_WAIT;
                     end
                  end
                  OP_PUSH: begin
                     load = 1'b1;
                     if (count_ff >= COUNT_W'(STACK_DEPTH)) begin
                        rsp_data_in.status = STATUS_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_BAD: begin
                     load               = 1'b1;
                     rsp_data_in.status = STATUS_BAD;
                  end
                  OP_QUERY: begin
                     load = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         default: state_in = ST_RUN;
      endcase
      rsp_data_in.free_bytes = bytes_of(count_in);
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_idx] <= q_data.page;
      end
      if (mem_re) begin
         rd_data_ff <= stack_mem[mem_idx];
      end
   end

endmodule

// ===== sv/free_page_stack_allocator.sv =====
// top level of the free page stack allocator
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_data   (command, address)
//   rsp      out        rsp_valid/rsp_ready    rsp_data   (page_address, free_bytes, status)
//   csr      in         psel/penable/pready    limit registers at 0x0 and 0x8
//
// free, query, rejected and empty-stack allocate commands load the result register
// directly; other allocates go through ST_POP_WAIT for the page stack memory's registered read.
// the front end takes a command every cycle while the two-entry queue has room.
// reset empties the stack and restores the limits; stack entries need no clearing.
// a result waiting in the output register stalls the back end, and the front end once the queue fills.
module free_page_stack_allocator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  fpsa_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output fpsa_pkg::rsp_type                 rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [fpsa_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [fpsa_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [fpsa_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import fpsa_pkg::*;

   limits_type limits;
   logic       fq_valid, fq_ready;
   entry_type  fq_data;
   logic       qb_valid, qb_ready;
   entry_type  qb_data;

   fpsa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .limits      (limits)
   );

   fpsa_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .limits    (limits),
      .q_valid   (fq_valid),
      .q_ready   (fq_ready),
      .q_data    (fq_data)
   );

   fpsa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   fpsa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (qb_valid),
      .q_ready   (qb_ready),
      .q_data    (qb_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== test/tb.sv =====
// self-checking testbench for the free page stack allocator
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fpsa_pkg::*;

   localparam logic [CMD_W-1:0]  CMD_UNUSED  = 2'd3;
   localparam logic [ADDR_W-1:0] ADDR_MAX    = '1;
   localparam int                STALL_LIMIT = 4000;
   localparam int                SETTLE      = 10;
   localparam int                PHASE_ITEMS = 260;

   // shadow copy of the page stack and the limits, plus the responses still owed
   class page_stack_shadow;
      logic [ADDR_W-1:0]     lower_limit;
      logic [ADDR_W-1:0]     upper_limit;
      logic [PAGE_NUM_W-1:0] pages [STACK_DEPTH];
      int unsigned           page_count;
      rsp_type               awaited [$];
      int unsigned           faults;
      int unsigned           status_tally [4];

      function new();
         lower_limit = LOWER_LIMIT_RESET;
         upper_limit = UPPER_LIMIT_RESET;
         page_count  = 0;
         faults      = 0;
         foreach (status_tally[i]) status_tally[i] = 0;
      endfunction

      function void note_command(req_type item);
         rsp_type     outcome;
         logic [63:0] bytes;
         outcome        = '0;
         outcome.status = STATUS_OK;
         if (item.command == CMD_ALLOC) begin
            if (page_count == 0) begin
               outcome.status = STATUS_EMPTY;
            end else begin
               page_count--;
               outcome.page_address = {pages[page_count], {PAGE_SHIFT{1'b0}}};
            end
         end else if (item.command == CMD_FREE) begin
            if (item.address[PAGE_SHIFT-1:0] != '0 || item.address < lower_limit
                || item.address >= upper_limit) begin
               outcome.status = STATUS_BAD;
            end else if (page_count >= STACK_DEPTH) begin
               outcome.status = STATUS_FULL;
            end else begin
               pages[page_count] = item.address[ADDR_W-1:PAGE_SHIFT];
               page_count++;
            end
         end
         // query and the unused code only report the running count
         bytes = 64'(page_count) * 64'(PAGE_BYTES);
         outcome.free_bytes = (bytes > 64'(BYTES_MAX)) ? BYTES_MAX : bytes[BYTES_W-1:0];
         awaited.push_back(outcome);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            $error("response transaction with nothing outstanding: %h", got);
            faults++;
            return;
         end
         want = awaited.pop_front();
         status_tally[got.status]++;
         if (got.page_address !== want.page_address) begin
            $error("page_address: expected %h, got %h", want.page_address, got.page_address);
            faults++;
         end
         if (got.free_bytes !== want.free_bytes) begin
            $error("free_bytes: expected %h, got %h", want.free_bytes, got.free_bytes);
            faults++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %h, got %h", want.status, got.status);
            faults++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   page_stack_shadow shadow = new();
   bit               pace_sender;
   bit               pace_receiver;
   int unsigned      stuck_cycles;
   int unsigned      limit_settings;

   free_page_stack_allocator u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   // a page-aligned address inside the current limits, or the fallback if there is none
   function automatic logic [ADDR_W-1:0] window_page(input logic [ADDR_W-1:0] fallback);
      logic [63:0] first_page;
      logic [63:0] last_page;
      if (shadow.upper_limit == '0) return fallback;
      first_page = (64'(shadow.lower_limit) + 64'(PAGE_BYTES - 1)) >> PAGE_SHIFT;
      last_page  = 64'(shadow.upper_limit - 1'b1) >> PAGE_SHIFT;
      if (first_page > last_page) return fallback;
      return {PAGE_NUM_W'($urandom_range(32'(first_page), 32'(last_page))),
              {PAGE_SHIFT{1'b0}}};
   endfunction

   // receiver: random stalls while pacing is on
   initial begin
      forever begin
         if (pace_receiver && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat (pick_gap()) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // transaction monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) shadow.note_command(req_data);
         if (rsp_valid && rsp_ready) shadow.check_response(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_psel && csr_penable)) begin
            stuck_cycles <= 0;
         end else if (stuck_cycles >= STALL_LIMIT) begin
            $display("free_page_stack_allocator verification failed");
            $finish;
         end else begin
            stuck_cycles <= stuck_cycles + 1;
         end
      end
   end

   task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr);
      req_type item;
      item.command = cmd;
      item.address = addr;
      if (pace_sender && $urandom_range(0, 9) < 3) begin
         req_valid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop sending and wait for every owed response; polled on the falling edge
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (shadow.awaited.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_limit(input logic reg_sel, input logic [ADDR_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 3'b000};
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (reg_sel == REG_LOWER_LIMIT) shadow.lower_limit = value;
      else shadow.upper_limit = value;
      // read it straight back
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[ADDR_W-1:0] !== value) begin
         $error("limit readback: expected %h, got %h", value, csr_prdata[ADDR_W-1:0]);
         shadow.faults++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic apply_limits(input logic [ADDR_W-1:0] lower, input logic [ADDR_W-1:0] upper);
      wait_drained();
      write_limit(REG_LOWER_LIMIT, lower);
      write_limit(REG_UPPER_LIMIT, upper);
      limit_settings++;
   endtask

   task automatic random_item();
      logic [ADDR_W-1:0] addr;
      int unsigned       pick;
      addr = ADDR_W'({$urandom(), $urandom()});
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         send_command(CMD_ALLOC, addr);
      end else if (pick < 88) begin
         // mostly legal frees, the rest junk or aligned but likely out of range
         if ($urandom_range(0, 3) != 0) addr = window_page(addr);
         else if ($urandom_range(0, 1) != 0) addr[PAGE_SHIFT-1:0] = '0;
         send_command(CMD_FREE, addr);
      end else if (pick < 96) begin
         send_command(CMD_QUERY, addr);
      end else begin
         send_command(CMD_UNUSED, addr);
      end
   endtask

   task automatic run_phase(input int items, input bit pause_midway);
      for (int i = 0; i < items; i++) begin
         if (pause_midway && i == items / 2) wait_drained();
         random_item();
      end
   endtask

   initial begin
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] a;
      logic [ADDR_W-1:0] b;

      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_data      <= '0;
      csr_psel      <= 1'b0;
      csr_penable   <= 1'b0;
      csr_pwrite    <= 1'b0;
      csr_paddr     <= '0;
      csr_pwdata    <= '0;
      stuck_cycles   = 0;
      limit_settings = 0;
      pace_sender    = 1'b1;
      pace_receiver  = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: limits at their reset values
      send_command(CMD_ALLOC, '0);
      send_command(CMD_QUERY, '0);
      send_command(CMD_UNUSED, ADDR_MAX);
      send_command(CMD_FREE, LOWER_LIMIT_RESET);
      send_command(CMD_FREE, UPPER_LIMIT_RESET - PAGE_BYTES);
      send_command(CMD_FREE, UPPER_LIMIT_RESET);
      send_command(CMD_FREE, LOWER_LIMIT_RESET - PAGE_BYTES);
      send_command(CMD_FREE, LOWER_LIMIT_RESET + 1);
      send_command(CMD_FREE, LOWER_LIMIT_RESET + PAGE_BYTES / 2);
      send_command(CMD_FREE, ADDR_MAX);
      send_command(CMD_FREE, '0);
      send_command(CMD_FREE, LOWER_LIMIT_RESET);   // double free goes through
      repeat (4) send_command(CMD_ALLOC, ADDR_MAX);

      // widest window: page zero and the top page are both legal
      apply_limits('0, ADDR_MAX);
      send_command(CMD_FREE, '0);
      send_command(CMD_FREE, {ADDR_MAX[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}});
      send_command(CMD_FREE, ADDR_MAX);
      send_command(CMD_ALLOC, '0);
      send_command(CMD_ALLOC, '0);
      send_command(CMD_QUERY, ADDR_MAX);

      // empty windows reject everything
      apply_limits(ADDR_W'(PAGE_BYTES), ADDR_W'(PAGE_BYTES));
      send_command(CMD_FREE, ADDR_W'(PAGE_BYTES));
      apply_limits(ADDR_MAX, ADDR_MAX);
      send_command(CMD_FREE, {ADDR_MAX[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}});

      // random traffic under several windows
      apply_limits(LOWER_LIMIT_RESET, UPPER_LIMIT_RESET);
      run_phase(PHASE_ITEMS, 1'b0);

      pace_sender   = 1'b0;
      pace_receiver = 1'b0;
      apply_limits('0, ADDR_MAX);
      run_phase(PHASE_ITEMS, 1'b0);
      pace_sender   = 1'b1;
      pace_receiver = 1'b1;

      // a handful of pages, so double frees and empty pops are frequent
      base = {PAGE_NUM_W'($urandom_range(1, 4000000)), {PAGE_SHIFT{1'b0}}};
      apply_limits(base + ADDR_W'($urandom_range(0, 1) * 100),
                   base + ADDR_W'(5 * PAGE_BYTES + $urandom_range(0, 1) * 100));
      run_phase(PHASE_ITEMS, 1'b1);

      a = ADDR_W'({$urandom(), $urandom()});
      b = ADDR_W'({$urandom(), $urandom()});
      apply_limits((a < b) ? a : b, (a < b) ? b : a);
      run_phase(PHASE_ITEMS, 1'b0);

      apply_limits(34'h2_0000_0000, 34'h1_0000_0000);
      run_phase(PHASE_ITEMS, 1'b0);

      // short directed tail in the widest window
      apply_limits('0, ADDR_MAX);
      send_command(CMD_FREE, ADDR_MAX);
      send_command(CMD_QUERY, '0);
      send_command(CMD_UNUSED, '0);
      repeat (3) send_command(CMD_ALLOC, '0);
      repeat (4) send_command(CMD_FREE, window_page('0));
      send_command(CMD_ALLOC, '0);

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      $display("ran %0d limit settings; responses: %0d ok, %0d empty,",
               limit_settings, shadow.status_tally[STATUS_OK], shadow.status_tally[STATUS_EMPTY]);
      $display("%0d bad free address, %0d stack full",
               shadow.status_tally[STATUS_BAD], shadow.status_tally[STATUS_FULL]);
      if (shadow.faults == 0 && shadow.awaited.size() == 0) begin
         $display("free_page_stack_allocator verification clean");
      end else begin
         $display("free_page_stack_allocator verification failed");
      end
      $finish;
   end

endmodule

// ===== free_page_stack_allocator.f =====
sv/fpsa_pkg.sv
sv/fpsa_csr.sv
sv/fpsa_front.sv
sv/fpsa_queue.sv
sv/fpsa_back.sv
sv/free_page_stack_allocator.sv
test/tb.sv
